// ===== hdl/mlfd_pkg.sv =====
package mlfd_pkg;

  // Fixed field widths of the stream beats
  localparam int unsigned JobW   = 8;
  localparam int unsigned LevelW = 2;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned EventW = 3;

  localparam int unsigned NumLevels = 4;
  localparam logic [LevelW-1:0] TopLevel = LevelW'(3);

  // Packed beat widths, padded to whole bytes
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;

  // Parameter defaults
  localparam int unsigned DefFifoDepth = 16;
  localparam int unsigned DefIdBits    = 8;
  localparam int unsigned DefTimeBits  = 16;

  typedef enum logic {
    OP_SUBMIT = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [EventW-1:0] {
    EV_IDLE     = 3'd0,
    EV_ACCEPTED = 3'd1,
    EV_DROPPED  = 3'd2,
    EV_START    = 3'd3,
    EV_RESUME   = 3'd4,
    EV_CONTINUE = 3'd5,
    EV_SUSPEND  = 3'd6,
    EV_TERM     = 3'd7
  } event_e;

  typedef enum logic {
    ST_ACCEPT = 1'b0,
    ST_FETCH  = 1'b1
  } state_e;

endpackage

// ===== hdl/multilevel_feedback_dispatcher_top.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: op; tdata: job_id, job_priority, run_time
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: event_res; tdata: event_job, event_level
//
// A submit beat, or a tick while a job runs or all queues are empty, loads the result
// register; its result beat is valid in the next cycle.
// A dispatching tick registers the head entry read from the queue memory, then
// loads the result in the fetch state, and input is held off meanwhile.
// Reset clears heads, counts and the running job; only counted entries are read.
// A held result beat (m_axis_tready low) holds off input until the beat leaves.
module multilevel_feedback_dispatcher_top
  import mlfd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = DefFifoDepth,
  parameter int unsigned ID_BITS    = DefIdBits,
  parameter int unsigned TIME_BITS  = DefTimeBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] job_id, [9:8] job_priority, [25:10] run_time, [31:26] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] op
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] event_job, [9:8] event_level, [15:10] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [2:0] event_res
  output logic [EventW-1:0]   m_axis_tuser
);

  localparam int unsigned PtrW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SumW  = CntW + 1;
  localparam int unsigned AddrW = LevelW + PtrW;
  localparam int unsigned MemD  = NumLevels * (2 ** PtrW);
  localparam int unsigned EntW  = 1 + TIME_BITS + ID_BITS;
  localparam int unsigned IdExtW   = (ID_BITS > JobW) ? ID_BITS : JobW;
  localparam int unsigned TimeExtW = (TIME_BITS > TimeW) ? TIME_BITS : TimeW;

  localparam logic [CntW-1:0] DepthCnt = CntW'(FIFO_DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(FIFO_DEPTH);

  // ---------------------------------------------------------------------------
  // Beat unpacking
  // ---------------------------------------------------------------------------
  logic                 in_fire;
  op_e                  in_op;
  logic [JobW-1:0]      in_job;
  logic [LevelW-1:0]    in_prio;
  logic [TimeW-1:0]     in_time;
  logic [IdExtW-1:0]    in_id_ext;
  logic [TimeExtW-1:0]  in_time_ext;
  logic [ID_BITS-1:0]   in_id;
  logic [TIME_BITS-1:0] in_rt;

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign in_op       = op_e'(s_axis_tuser);
  assign in_job      = s_axis_tdata[7:0];
  assign in_prio     = s_axis_tdata[9:8];
  assign in_time     = s_axis_tdata[25:10];
  assign in_id_ext   = IdExtW'(in_job);
  assign in_time_ext = TimeExtW'(in_time);
  assign in_id       = in_id_ext[ID_BITS-1:0];
  assign in_rt       = in_time_ext[TIME_BITS-1:0];

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e st_q, st_d;

  logic [PtrW-1:0] head_q [NumLevels];
  logic [PtrW-1:0] head_d [NumLevels];
  logic [CntW-1:0] cnt_q  [NumLevels];
  logic [CntW-1:0] cnt_d  [NumLevels];

  logic                 run_valid_q, run_valid_d;
  logic [ID_BITS-1:0]   run_job_q, run_job_d;
  logic [LevelW-1:0]    run_lvl_q, run_lvl_d;
  logic [TIME_BITS-1:0] run_rem_q, run_rem_d;

  logic [LevelW-1:0] pick_lvl_q, pick_lvl_d;

  // Result register
  logic              out_valid_q;
  event_e            out_res_q;
  logic [JobW-1:0]   out_job_q;
  logic [LevelW-1:0] out_lvl_q;

  // Queue memory: {started, remaining time, id}, addressed {level, slot}
  logic [EntW-1:0]  mem_q [MemD];
  logic [EntW-1:0]  rd_data_q;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [EntW-1:0]  wr_data;

  // ---------------------------------------------------------------------------
  // Queue pointers
  // ---------------------------------------------------------------------------
  logic [PtrW-1:0]   tail_pos [NumLevels];
  logic [PtrW-1:0]   head_nxt [NumLevels];
  logic [SumW-1:0]   tail_sum [NumLevels];
  logic [SumW-1:0]   tail_wrap [NumLevels];
  logic [SumW-1:0]   head_inc [NumLevels];
  logic [NumLevels-1:0] has_room, nonempty;
  logic              any_wait;
  logic [LevelW-1:0] pick_lvl;

  always_comb begin
    for (int l = 0; l < NumLevels; l++) begin
      tail_sum[l]  = SumW'(head_q[l]) + SumW'(cnt_q[l]);
      tail_wrap[l] = (tail_sum[l] >= DepthSum) ? (tail_sum[l] - DepthSum) : tail_sum[l];
      tail_pos[l]  = tail_wrap[l][PtrW-1:0];
      head_inc[l]  = SumW'(head_q[l]) + SumW'(1);
      head_nxt[l]  = (head_inc[l] == DepthSum) ? '0 : head_inc[l][PtrW-1:0];
      has_room[l]  = (cnt_q[l] < DepthCnt);
      nonempty[l]  = (cnt_q[l] != '0);
    end
  end

  assign any_wait = |nonempty;

  // Highest non-empty level, level 0 first
  always_comb begin
    pick_lvl = '0;
    for (int l = NumLevels - 1; l >= 0; l--) begin
      if (nonempty[l]) begin
        pick_lvl = LevelW'(l);
      end
    end
  end

  function automatic logic [JobW-1:0] id_to_job(input logic [ID_BITS-1:0] v);
    logic [IdExtW-1:0] e;
    e = IdExtW'(v);
    return e[JobW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // State machine
  // ---------------------------------------------------------------------------
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_ACCEPT: begin
        if (in_fire && (in_op == OP_TICK) && !run_valid_q && any_wait) begin
          st_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        st_d = ST_ACCEPT;
      end
      default: begin
        st_d = ST_ACCEPT;
      end
    endcase
  end

  always_comb begin
    unique case (st_q)
      ST_ACCEPT: s_axis_tready = !out_valid_q || m_axis_tready;
      ST_FETCH:  s_axis_tready = 1'b0;
      default:   s_axis_tready = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath: read-modify-write of queue state and running job
  // ---------------------------------------------------------------------------
  logic [LevelW-1:0]    demote_lvl;
  logic [TIME_BITS-1:0] rem_dec;
  logic                 ev_load;
  event_e               ev_res;
  logic [JobW-1:0]      ev_job;
  logic [LevelW-1:0]    ev_lvl;
  logic                 fetch_started;
  logic [TIME_BITS-1:0] fetch_time;
  logic [ID_BITS-1:0]   fetch_id;

  assign demote_lvl = (run_lvl_q < TopLevel) ? (run_lvl_q + LevelW'(1)) : TopLevel;
  assign rem_dec    = run_rem_q - TIME_BITS'(1);
  assign {fetch_started, fetch_time, fetch_id} = rd_data_q;

  always_comb begin
    head_d      = head_q;
    cnt_d       = cnt_q;
    run_valid_d = run_valid_q;
    run_job_d   = run_job_q;
    run_lvl_d   = run_lvl_q;
    run_rem_d   = run_rem_q;
    pick_lvl_d  = pick_lvl_q;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    ev_load     = 1'b0;
    ev_res      = EV_IDLE;
    ev_job      = '0;
    ev_lvl      = '0;

    if (in_fire) begin
      if (in_op == OP_SUBMIT) begin
        ev_load = 1'b1;
        ev_job  = in_job;
        ev_lvl  = in_prio;
        if (has_room[in_prio]) begin
          wr_en          = 1'b1;
          wr_addr        = {in_prio, tail_pos[in_prio]};
          wr_data        = {1'b0, in_rt, in_id};
          cnt_d[in_prio] = cnt_q[in_prio] + CntW'(1);
          ev_res         = EV_ACCEPTED;
        end else begin
          ev_res = EV_DROPPED;
        end
      end else if (run_valid_q) begin
        ev_load = 1'b1;
        ev_job  = id_to_job(run_job_q);
        ev_lvl  = run_lvl_q;
        if (run_rem_q <= TIME_BITS'(1)) begin
          // Last tick of the job
          run_rem_d   = '0;
          run_valid_d = 1'b0;
          ev_res      = EV_TERM;
        end else begin
          run_rem_d = rem_dec;
          ev_res    = EV_CONTINUE;
          // Preempt a user job in favor of waiting work, if its demotion level (capped at the bottom) has room
          if ((run_lvl_q != '0) && any_wait && has_room[demote_lvl]) begin
            wr_en             = 1'b1;
            wr_addr           = {demote_lvl, tail_pos[demote_lvl]};
            wr_data           = {1'b1, rem_dec, run_job_q};
            cnt_d[demote_lvl] = cnt_q[demote_lvl] + CntW'(1);
            run_valid_d       = 1'b0;
            run_lvl_d         = demote_lvl;
            ev_res            = EV_SUSPEND;
            ev_lvl            = demote_lvl;
          end
        end
      end else if (any_wait) begin
        // Dispatch: fetch the head entry, finish next cycle
        rd_en      = 1'b1;
        rd_addr    = {pick_lvl, head_q[pick_lvl]};
        pick_lvl_d = pick_lvl;
      end else begin
        ev_load = 1'b1;
        ev_res  = EV_IDLE;
      end
    end

    if (st_q == ST_FETCH) begin
      run_valid_d        = 1'b1;
      run_job_d          = fetch_id;
      run_lvl_d          = pick_lvl_q;
      run_rem_d          = fetch_time;
      head_d[pick_lvl_q] = head_nxt[pick_lvl_q];
      cnt_d[pick_lvl_q]  = cnt_q[pick_lvl_q] - CntW'(1);
      ev_load            = 1'b1;
      ev_res             = fetch_started ? EV_RESUME : EV_START;
      ev_job             = id_to_job(fetch_id);
      ev_lvl             = pick_lvl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_ACCEPT;
      run_valid_q <= 1'b0;
      run_job_q   <= '0;
      run_lvl_q   <= '0;
      run_rem_q   <= '0;
      pick_lvl_q  <= '0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < NumLevels; l++) begin
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      st_q        <= st_d;
      run_valid_q <= run_valid_d;
      run_job_q   <= run_job_d;
      run_lvl_q   <= run_lvl_d;
      run_rem_q   <= run_rem_d;
      pick_lvl_q  <= pick_lvl_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      // Load a new result beat, or drop the held one once taken
      if (ev_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_load) begin
      out_res_q <= ev_res;
      out_job_q <= ev_job;
      out_lvl_q <= ev_lvl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Result beat
  // ---------------------------------------------------------------------------
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q;
  assign m_axis_tdata  = {(OutDataW - JobW - LevelW)'(0), out_lvl_q, out_job_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fetch_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FETCH) |=> (out_valid_q && run_valid_q))
    else $error("dispatch did not load a result and a running job");

  a_fetch_needs_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FETCH) |-> (!out_valid_q))
    else $error("dispatch result would overwrite a held beat");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= DepthCnt) && (cnt_q[1] <= DepthCnt) &&
    (cnt_q[2] <= DepthCnt) && (cnt_q[3] <= DepthCnt))
    else $error("queue count exceeds depth");

  a_no_dispatch_while_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (!run_valid_q && any_wait))
    else $error("queue read while a job runs or queues are empty");

  a_terminate_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_op == OP_TICK) && run_valid_q && (run_rem_q <= TIME_BITS'(1)))
      |=> (!run_valid_q && (out_res_q == EV_TERM)))
    else $error("terminating job still marked running");

endmodule

// ===== tb/sv/multilevel_feedback_dispatcher_top_tb.sv =====
`timescale 1ns / 1ps

module multilevel_feedback_dispatcher_top_tb;
  import mlfd_pkg::*;

  localparam int QDepth        = DefFifoDepth;
  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 450;

  typedef struct {
    op_e              op;
    logic [JobW-1:0]  id;
    logic [LevelW-1:0] prio;
    logic [TimeW-1:0] rt;
  } dispatch_cmd_t;

  typedef struct {
    event_e            code;
    logic [JobW-1:0]   job;
    logic [LevelW-1:0] level;
  } dispatch_event_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [7:0] job_id, [9:8] job_priority, [25:10] run_time, [31:26] zero
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  // [0] op
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  // [7:0] event_job, [9:8] event_level, [15:10] zero
  logic [OutDataW-1:0] m_axis_tdata;
  // [2:0] event_res
  logic [EventW-1:0]   m_axis_tuser;

  multilevel_feedback_dispatcher_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Commands still to be driven, and dispatcher events still to be seen
  dispatch_cmd_t   dispatcher_cmds[$];
  dispatch_event_t expected_events[$];

  int mismatch_cnt = 0;
  int idle_cycles  = 0;
  bit in_taken     = 1'b0;
  bit out_taken    = 1'b0;
  int in_gap       = 0;
  int out_stall    = 0;
  bit in_burst     = 1'b0;
  bit out_burst    = 1'b0;

  // Shadow copy of the dispatcher: one FIFO per level plus the running job
  logic [JobW-1:0]  slot_job     [NumLevels][QDepth];
  logic [TimeW-1:0] slot_time    [NumLevels][QDepth];
  bit               slot_started [NumLevels][QDepth];
  int               lvl_head     [NumLevels];
  int               lvl_count    [NumLevels];
  bit                run_active = 1'b0;
  logic [JobW-1:0]   run_job    = '0;
  logic [LevelW-1:0] run_level  = '0;
  logic [TimeW-1:0]  run_left   = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit level_push(logic [LevelW-1:0] lvl, logic [JobW-1:0] id,
                                    logic [TimeW-1:0] t, bit started);
    int pos;
    if (lvl_count[lvl] >= QDepth) return 1'b0;
    pos = (lvl_head[lvl] + lvl_count[lvl]) % QDepth;
    slot_job[lvl][pos]     = id;
    slot_time[lvl][pos]    = t;
    slot_started[lvl][pos] = started;
    lvl_count[lvl]++;
    return 1'b1;
  endfunction

  function automatic bit jobs_waiting();
    int l;
    for (l = 0; l < NumLevels; l++)
      if (lvl_count[l] != 0) return 1'b1;
    return 1'b0;
  endfunction

  // Advance the shadow dispatcher by one command and return the event it raises
  function automatic dispatch_event_t dispatch_outcome(dispatch_cmd_t c);
    dispatch_event_t   ev;
    logic [LevelW-1:0] nl;
    int                l;
    bit                found;
    ev    = '{EV_IDLE, '0, '0};
    found = 1'b0;
    if (c.op == OP_SUBMIT) begin
      ev.job   = c.id;
      ev.level = c.prio;
      ev.code  = level_push(c.prio, c.id, c.rt, 1'b0) ? EV_ACCEPTED : EV_DROPPED;
    end else if (run_active) begin
      if (run_left <= 1) begin
        // time used up: retire the job
        run_left   = '0;
        run_active = 1'b0;
        ev = '{EV_TERM, run_job, run_level};
      end else begin
        run_left = run_left - 1'b1;
        ev = '{EV_CONTINUE, run_job, run_level};
        // user job yields to waiting work unless its demotion FIFO is full
        if (run_level != 0 && jobs_waiting()) begin
          nl = (run_level < TopLevel) ? run_level + 1'b1 : TopLevel;
          if (level_push(nl, run_job, run_left, 1'b1)) begin
            run_active = 1'b0;
            run_level  = nl;
            ev = '{EV_SUSPEND, run_job, nl};
          end
        end
      end
    end else begin
      // idle: pick the head of the highest non-empty level
      for (l = 0; l < NumLevels; l++) begin
        if (!found && lvl_count[l] != 0) begin
          found      = 1'b1;
          run_active = 1'b1;
          run_job    = slot_job[l][lvl_head[l]];
          run_left   = slot_time[l][lvl_head[l]];
          run_level  = LevelW'(l);
          ev = '{slot_started[l][lvl_head[l]] ? EV_RESUME : EV_START, run_job, run_level};
          lvl_head[l] = (lvl_head[l] + 1) % QDepth;
          lvl_count[l]--;
        end
      end
    end
    return ev;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic add_cmd(op_e op, int id, int prio, int rt);
    dispatcher_cmds.push_back('{op, JobW'(id), LevelW'(prio), TimeW'(rt)});
  endtask

  // Short times at level 0 so no real-time job hogs the run; user jobs now
  // and then carry a long time and end up parked at the bottom level.
  function automatic int pick_run_time(int prio);
    if (prio != 0 && $urandom_range(0, 7) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, prio == 0 ? 6 : 8);
  endfunction

  task automatic add_random_submit(int prio);
    add_cmd(OP_SUBMIT, $urandom_range(0, 255), prio, pick_run_time(prio));
  endtask

  // Driver: present the next command at the falling edge, honoring a per-beat gap
  always @(negedge clk_i) begin : drive_cmds
    dispatch_cmd_t c;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (in_gap != 0) begin
        in_gap = in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (dispatcher_cmds.size() != 0) begin
        c = dispatcher_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.op;
        s_axis_tdata  <= {{(InDataW - TimeW - LevelW - JobW){1'b0}}, c.rt, c.prio, c.id};
        // gap that follows this beat; bursts run with no gaps at all
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 5);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: after each result beat, hold tready low for a drawn number of cycles
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 5);
      end
      if (out_stall != 0) begin
        out_stall = out_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every accepted command beat, check every result beat
  always @(posedge clk_i) begin : watch_beats
    dispatch_cmd_t   c;
    dispatch_event_t want;
    in_taken  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_taken <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        c.op   = op_e'(s_axis_tuser);
        c.id   = s_axis_tdata[JobW-1:0];
        c.prio = s_axis_tdata[JobW +: LevelW];
        c.rt   = s_axis_tdata[JobW+LevelW +: TimeW];
        expected_events.push_back(dispatch_outcome(c));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_events.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", m_axis_tuser, -1);
        end else begin
          want = expected_events.pop_front();
          if (m_axis_tuser != want.code)
            report_mismatch("event_res", m_axis_tuser, want.code);
          if (m_axis_tdata[JobW-1:0] != want.job)
            report_mismatch("event_job", m_axis_tdata[JobW-1:0], want.job);
          if (m_axis_tdata[JobW +: LevelW] != want.level)
            report_mismatch("event_level", m_axis_tdata[JobW +: LevelW], want.level);
        end
      end
      // watchdog: count cycles with no beat moving on either side
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int kind;
    int n;
    int lvl;
    int i;
    bit timed_out;
    for (i = 0; i < NumLevels; i++) begin
      lvl_head[i]  = 0;
      lvl_count[i] = 0;
    end

    // Directed: idle tick, zero run time at level 0, id extremes, longest run
    // time, suspension with demotion and its cap at the bottom level.
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_SUBMIT, 0,     0, 0);
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_SUBMIT, 255,   1, 65535);
    add_cmd(OP_SUBMIT, 'h5a,  2, 1);
    add_cmd(OP_TICK,   255,   3, 65535);
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_SUBMIT, 'h11,  3, 3);
    add_cmd(OP_SUBMIT, 'h22,  3, 2);
    add_cmd(OP_SUBMIT, 'h33,  0, 1);
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_TICK,   0,     0, 0);
    add_cmd(OP_TICK,   0,     0, 0);

    // Random episodes: mixed traffic, level floods that hit full FIFOs and full
    // demotion targets, long tick runs that drain, and a little pure noise.
    while (dispatcher_cmds.size() < RandomItems + 21) begin
      kind = $urandom_range(0, 19);
      if (kind < 10) begin
        n = $urandom_range(5, 20);
        for (i = 0; i < n; i++)
          if ($urandom_range(0, 99) < 55) add_cmd(OP_TICK, 0, 0, 0);
          else add_random_submit($urandom_range(0, 3));
      end else if (kind < 14) begin
        lvl = $urandom_range(0, 3);
        n = $urandom_range(14, 20);
        for (i = 0; i < n; i++) add_random_submit(lvl);
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          add_cmd(OP_TICK, 0, 0, 0);
          add_random_submit(lvl);
          add_cmd(OP_TICK, 0, 0, 0);
        end
      end else if (kind < 18) begin
        n = $urandom_range(10, 40);
        for (i = 0; i < n; i++) add_cmd(OP_TICK, 0, 0, 0);
      end else begin
        // noise: any field values on ticks, submits at user levels with any time
        n = $urandom_range(3, 8);
        for (i = 0; i < n; i++)
          if ($urandom_range(0, 1) == 0)
            add_cmd(OP_TICK, $urandom_range(0, 255), $urandom_range(0, 3),
                    $urandom_range(0, 65535));
          else
            add_cmd(OP_SUBMIT, $urandom_range(0, 255), $urandom_range(1, 3),
                    $urandom_range(0, 65535));
      end
    end
    // Longest real-time job last, so it cannot starve the rest of the run
    add_cmd(OP_SUBMIT, $urandom_range(0, 255), 0, 65535);
    for (i = 0; i < 3; i++) add_cmd(OP_TICK, 0, 0, 0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (idle_cycles < WatchdogLimit &&
           (dispatcher_cmds.size() != 0 || s_axis_tvalid || expected_events.size() != 0))
      @(posedge clk_i);
    timed_out = (idle_cycles >= WatchdogLimit);
    // let any stray beat show up before the verdict
    repeat (10) @(posedge clk_i);

    if (!timed_out && mismatch_cnt == 0 && expected_events.size() == 0)
      $display("[multilevel_feedback_dispatcher_top] OK");
    else
      $display("[multilevel_feedback_dispatcher_top] ERROR");
    $finish;
  end

endmodule
